/* rtl/ipbm_pkg.sv */
// ----------------------------------------------------------------------------
// ipbm_pkg
// Shared types and codes for the I/O port permission bitmap block.
// ----------------------------------------------------------------------------
package ipbm_pkg;

	localparam int PORT_W  = 16;
	localparam int COUNT_W = 17;
	localparam int END_W   = 18;
	localparam int WORD_W  = PORT_W - 5;
	localparam int DATA_W  = 32;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_NOPERM  = 2'd2;

	typedef struct packed {
		logic               command;
		logic [PORT_W-1:0]  first_port;
		logic [COUNT_W-1:0] port_count;
		logic               grant;
		logic               privileged;
	} ipbm_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       port_allowed;
	} ipbm_rsp_t;

	typedef struct packed {
		logic [WORD_W-1:0] first_word;
		logic [WORD_W-1:0] last_word;
		logic [4:0]        lo_bit;
		logic [4:0]        hi_bit;
		logic              grant;
	} ipbm_range_t;

endpackage

/* rtl/ipbm_ram.sv */
// ----------------------------------------------------------------------------
// ipbm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ipbm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* rtl/ipbm_mask.sv */
// ----------------------------------------------------------------------------
// ipbm_mask
// Range mask and set/clear unit, applied to one bitmap word per cycle.
// ----------------------------------------------------------------------------
module ipbm_mask (
	input  ipbm_pkg::ipbm_range_t       rng,
	input  logic [ipbm_pkg::WORD_W-1:0] index,
	input  logic [ipbm_pkg::DATA_W-1:0] old_word,
	output logic [ipbm_pkg::DATA_W-1:0] new_word
);
	import ipbm_pkg::*;

	logic [DATA_W-1:0] lo_mask;
	logic [DATA_W-1:0] hi_mask;
	logic [DATA_W-1:0] mask;

	always_comb begin
		lo_mask  = (index == rng.first_word) ? ({DATA_W{1'b1}} << rng.lo_bit)
			: {DATA_W{1'b1}};
		hi_mask  = (index == rng.last_word) ? ~({{(DATA_W-1){1'b1}}, 1'b0} << rng.hi_bit)
			: {DATA_W{1'b1}};
		mask     = lo_mask & hi_mask;
		new_word = rng.grant ? (old_word & ~mask) : (old_word | mask);
	end

endmodule

/* rtl/io_permission_bitmap_range_update.sv */
// Update: accept, a check state, a walk state that reads and writes back each word
// touched, then a result state; the next request is accepted after the result.
// Query: check, a data read, then the result; rejected requests skip straight to it.
// Throughput is one item at a time, bounded by the single RAM read/write port pair.
// Reset: a clearing pass writes all ones to BITMAP_WORDS words, one per cycle,
// with req_ready low; the response register comes out of reset empty.
// ----------------------------------------------------------------------------
// io_permission_bitmap_range_update
// I/O port permission bitmap with range grant/revoke and single-port query.
// ----------------------------------------------------------------------------
module io_permission_bitmap_range_update #(
	parameter int BITMAP_WORDS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ipbm_pkg::ipbm_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ipbm_pkg::ipbm_rsp_t rsp
);
	import ipbm_pkg::*;

	localparam int ADDR_W      = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
	localparam int TOTAL_PORTS = BITMAP_WORDS * 32;
	localparam logic [END_W-1:0]  TOTAL     = END_W'(TOTAL_PORTS);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BITMAP_WORDS - 1);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_CHECK,
		S_WALK,
		S_QDATA,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] init_q;
	ipbm_req_t         req_q;
	logic [WORD_W-1:0] ptr_q;
	logic [WORD_W-1:0] wr_ptr_q;
	logic [WORD_W-1:0] last_q;
	logic [4:0]        hi_q;
	logic              rd_done_q;
	logic              pend_q;
	logic [1:0]        status_q;
	logic              allowed_q;
	logic              rsp_valid_q;
	ipbm_rsp_t         rsp_q;

	logic [END_W-1:0]  end_sum;
	logic [END_W-1:0]  end_m1;
	logic              range_bad;
	logic              query_bad;
	logic [WORD_W-1:0] first_word;
	ipbm_range_t       rng;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic [ADDR_W-1:0] rd_addr;
	logic [DATA_W-1:0] rd_data;
	logic [DATA_W-1:0] upd_word;

	always_comb begin
		end_sum    = END_W'(req_q.first_port) + END_W'(req_q.port_count);
		end_m1     = end_sum - END_W'(1);
		range_bad  = (req_q.port_count == '0) || (end_sum > TOTAL);
		query_bad  = (END_W'(req_q.first_port) >= TOTAL);
		first_word = req_q.first_port[PORT_W-1:5];

		rng.first_word = first_word;
		rng.last_word  = last_q;
		rng.lo_bit     = req_q.first_port[4:0];
		rng.hi_bit     = hi_q;
		rng.grant      = req_q.grant;

		wr_en   = (state_q == S_INIT) || ((state_q == S_WALK) && pend_q);
		wr_addr = (state_q == S_INIT) ? init_q : wr_ptr_q[ADDR_W-1:0];
		wr_data = (state_q == S_INIT) ? {DATA_W{1'b1}} : upd_word;
		rd_addr = (state_q == S_WALK) ? ptr_q[ADDR_W-1:0] : first_word[ADDR_W-1:0];
	end

	ipbm_mask u_mask (
		.rng      (rng),
		.index    (wr_ptr_q),
		.old_word (rd_data),
		.new_word (upd_word)
	);

	ipbm_ram #(
		.WIDTH (DATA_W),
		.DEPTH (BITMAP_WORDS),
		.AW    (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_q      <= '0;
			req_q       <= '0;
			ptr_q       <= '0;
			wr_ptr_q    <= '0;
			last_q      <= '0;
			hi_q        <= '0;
			rd_done_q   <= 1'b0;
			pend_q      <= 1'b0;
			status_q    <= STATUS_OK;
			allowed_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + ADDR_W'(1);
					if (init_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					allowed_q <= 1'b0;
					if (req_q.command == CMD_QUERY) begin
						if (query_bad) begin
							status_q <= STATUS_INVALID;
							state_q  <= S_DONE;
						end else begin
							status_q <= STATUS_OK;
							state_q  <= S_QDATA;
						end
					end else if (range_bad) begin
						status_q <= STATUS_INVALID;
						state_q  <= S_DONE;
					end else if (!req_q.privileged) begin
						status_q <= STATUS_NOPERM;
						state_q  <= S_DONE;
					end else begin
						status_q  <= STATUS_OK;
						ptr_q     <= first_word;
						last_q    <= end_m1[PORT_W-1:5];
						hi_q      <= end_m1[4:0];
						rd_done_q <= 1'b0;
						pend_q    <= 1'b0;
						state_q   <= S_WALK;
					end
				end
				S_WALK: begin
					pend_q   <= !rd_done_q;
					wr_ptr_q <= ptr_q;
					if (!rd_done_q) begin
						ptr_q <= ptr_q + WORD_W'(1);
						if (ptr_q == last_q) begin
							rd_done_q <= 1'b1;
						end
					end
					if (rd_done_q && !pend_q) begin
						state_q <= S_DONE;
					end
				end
				S_QDATA: begin
					allowed_q <= ~rd_data[req_q.first_port[4:0]];
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q.status       <= status_q;
						rsp_q.port_allowed <= allowed_q;
						rsp_valid_q        <= 1'b1;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* rtl/ipbm_checker.sv */
// ----------------------------------------------------------------------------
// ipbm_checker
// Port-level checks for the I/O port permission bitmap block.
// ----------------------------------------------------------------------------
module ipbm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input ipbm_pkg::ipbm_req_t req,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input ipbm_pkg::ipbm_rsp_t rsp
);
	import ipbm_pkg::*;

	// hold busy after an accepted request
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |-> ##1 !req_ready ##1 !req_ready)
		else $error("ipbm: ready too early after request");

	a_allowed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.port_allowed) |-> (rsp.status == STATUS_OK))
		else $error("ipbm: port allowed with error status");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
		else $error("ipbm: stalled response changed");

endmodule

bind io_permission_bitmap_range_update ipbm_checker u_ipbm_checker (.*);

/* tb/sv/io_permission_bitmap_range_update_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io_permission_bitmap_range_update_tb
// Drives grant/revoke range updates and single-port queries into the bitmap
// block with random gaps and response stalls. A scoreboard keeps a shadow copy
// of the bitmap, predicts each request's status and query answer, and compares
// every response in order.
// ----------------------------------------------------------------------------
module io_permission_bitmap_range_update_tb;
	import ipbm_pkg::*;

	localparam int MAP_WORDS = 32;
	localparam int MAP_PORTS = MAP_WORDS * 32;

	class bitmap_scoreboard;
		logic [DATA_W-1:0] words [MAP_WORDS];
		ipbm_rsp_t         expected_q [$];
		int                errors;

		function new();
			foreach (words[i]) words[i] = '1;
			errors = 0;
		endfunction

		function logic [DATA_W-1:0] span_mask(int unsigned w, int unsigned lo,
				int unsigned hi);
			int unsigned base;
			int unsigned s;
			int unsigned e;
			logic [DATA_W-1:0] upper;
			logic [DATA_W-1:0] lower;
			base = w * 32;
			s = (lo > base) ? lo - base : 0;
			e = (hi < base + 32) ? hi - base : 32;
			if (s >= e) return '0;
			upper = (e >= 32) ? '1 : ((32'd1 << e) - 32'd1);
			lower = (32'd1 << s) - 32'd1;
			return upper & ~lower;
		endfunction

		function void note_request(ipbm_req_t r);
			ipbm_rsp_t         want;
			int unsigned       range_end;
			int unsigned       first;
			logic [DATA_W-1:0] m;
			want.status = STATUS_OK;
			want.port_allowed = 1'b0;
			first = r.first_port;
			if (r.command == CMD_QUERY) begin
				if (first >= MAP_PORTS) begin
					want.status = STATUS_INVALID;
				end else begin
					want.port_allowed = ~words[first >> 5][first & 31];
				end
			end else begin
				range_end = first + int'(r.port_count);
				if (r.port_count == 0 || range_end > MAP_PORTS) begin
					want.status = STATUS_INVALID;
				end else if (!r.privileged) begin
					want.status = STATUS_NOPERM;
				end else begin
					for (int unsigned w = first >> 5; w <= (range_end - 1) >> 5; w++) begin
						m = span_mask(w, first, range_end);
						if (r.grant) words[w] &= ~m;
						else words[w] |= m;
					end
				end
			end
			expected_q.push_back(want);
		endfunction

		function void check_response(ipbm_rsp_t got);
			ipbm_rsp_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected response: status %0d port_allowed %0d",
					got.status, got.port_allowed);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.port_allowed !== want.port_allowed) begin
				$error("port_allowed: expected %0d, actual %0d",
					want.port_allowed, got.port_allowed);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	ipbm_req_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	ipbm_rsp_t rsp;

	bitmap_scoreboard sb;
	bit               calm = 1'b0;
	int               edge_lo = 0;
	int               edge_hi = 0;

	io_permission_bitmap_range_update #(
		.BITMAP_WORDS(MAP_WORDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int roll;
		if (calm) return 0;
		roll = $urandom_range(9);
		if (roll < 6) return 0;
		if (roll < 8) return $urandom_range(1, 3);
		if (roll < 9) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic ipbm_req_t make_req(logic cmd, int first, int count, logic grant,
			logic priv);
		ipbm_req_t r;
		r.command = cmd;
		r.first_port = PORT_W'(first);
		r.port_count = COUNT_W'(count);
		r.grant = grant;
		r.privileged = priv;
		return r;
	endfunction

	function automatic ipbm_req_t random_request();
		ipbm_req_t r;
		int        kind;
		int        count;
		int        first;
		int        size_roll;
		kind = $urandom_range(99);
		if (kind < 45) begin
			size_roll = $urandom_range(9);
			if (size_roll < 7) count = $urandom_range(1, 40);
			else if (size_roll < 9) count = $urandom_range(1, 200);
			else count = $urandom_range(1, MAP_PORTS);
			first = $urandom_range(0, MAP_PORTS - count);
			edge_lo = first;
			edge_hi = first + count;
			r = make_req(CMD_UPDATE, first, count, 1'($urandom_range(1)),
				1'($urandom_range(9) != 0));
		end else if (kind < 85) begin
			if ($urandom_range(9) < 6) begin
				case ($urandom_range(3))
					0: first = edge_lo - 1;
					1: first = edge_lo;
					2: first = edge_hi - 1;
					default: first = edge_hi;
				endcase
				if (first < 0) first = 0;
			end else begin
				first = $urandom_range(0, MAP_PORTS - 1);
			end
			r = make_req(CMD_QUERY, first, $urandom_range(0, 131071), 1'($urandom_range(1)),
				1'($urandom_range(1)));
		end else begin
			r = make_req(1'($urandom_range(1)), $urandom_range(0, 65535),
				$urandom_range(0, 131071), 1'($urandom_range(1)), 1'($urandom_range(1)));
		end
		return r;
	endfunction

	task automatic drive_request(input ipbm_req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sb.note_request(r);
	endtask

	initial begin : response_sink
		int stall_left;
		int seen;
		bit pressed;
		stall_left = 0;
		seen = 0;
		pressed = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				sb.check_response(rsp);
				seen++;
			end
			if (!pressed && seen >= 200) begin
				pressed = 1'b1;
				stall_left = 400;
			end else if (stall_left == 0) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		#1000000;
		$display("io_permission_bitmap_range_update_tb: errors");
		$finish;
	end

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		drive_request(make_req(CMD_QUERY, 0, 0, 1'b0, 1'b0));
		drive_request(make_req(CMD_UPDATE, 0, 0, 1'b1, 1'b1));
		drive_request(make_req(CMD_UPDATE, 0, 65536, 1'b1, 1'b1));
		drive_request(make_req(CMD_UPDATE, 65535, 1, 1'b1, 1'b1));
		drive_request(make_req(CMD_UPDATE, 0, MAP_PORTS, 1'b1, 1'b0));
		drive_request(make_req(CMD_UPDATE, 0, MAP_PORTS, 1'b1, 1'b1));
		drive_request(make_req(CMD_QUERY, MAP_PORTS - 1, 131071, 1'b0, 1'b0));
		drive_request(make_req(CMD_QUERY, MAP_PORTS, 0, 1'b1, 1'b1));
		drive_request(make_req(CMD_QUERY, 65535, 0, 1'b0, 1'b0));
		drive_request(make_req(CMD_UPDATE, 5, 3, 1'b0, 1'b1));
		drive_request(make_req(CMD_QUERY, 4, 0, 1'b0, 1'b0));
		drive_request(make_req(CMD_QUERY, 5, 0, 1'b0, 1'b0));
		drive_request(make_req(CMD_QUERY, 7, 0, 1'b0, 1'b0));
		drive_request(make_req(CMD_QUERY, 8, 0, 1'b0, 1'b0));
		drive_request(make_req(CMD_UPDATE, 30, 40, 1'b0, 1'b1));
		drive_request(make_req(CMD_UPDATE, MAP_PORTS - 1, 1, 1'b0, 1'b1));
		drive_request(make_req(CMD_QUERY, MAP_PORTS - 1, 0, 1'b0, 1'b0));
		drive_request(make_req(CMD_UPDATE, 1000, 24, 1'b1, 1'b1));
		drive_request(make_req(CMD_UPDATE, 1000, 25, 1'b0, 1'b1));
		drive_request(make_req(CMD_UPDATE, 32, 32, 1'b0, 1'b1));
		drive_request(make_req(CMD_QUERY, 31, 0, 1'b0, 1'b0));
		drive_request(make_req(CMD_QUERY, 32, 0, 1'b0, 1'b0));
		drive_request(make_req(CMD_QUERY, 63, 0, 1'b0, 1'b0));
		drive_request(make_req(CMD_QUERY, 64, 0, 1'b0, 1'b0));

		for (int i = 0; i < 700; i++) begin
			if (i % 100 == 0) calm = ($urandom_range(3) == 0);
			drive_request(random_request());
		end
		req_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0) begin
			$display("io_permission_bitmap_range_update_tb: clean");
		end else begin
			$display("io_permission_bitmap_range_update_tb: errors");
		end
		$finish;
	end
endmodule

/* files.f */
rtl/ipbm_pkg.sv
rtl/ipbm_ram.sv
rtl/ipbm_mask.sv
rtl/io_permission_bitmap_range_update.sv
rtl/ipbm_checker.sv
tb/sv/io_permission_bitmap_range_update_tb.sv
